// ===== sv/pso_particle_update_du_clamp_macros.svh =====
// ----------------------------------------------------------------------------
// pso particle update assertion macros
// shared property wrappers for the checker of the particle update block
// ----------------------------------------------------------------------------
`ifndef PSO_PARTICLE_UPDATE_DU_CLAMP_MACROS_SVH
`define PSO_PARTICLE_UPDATE_DU_CLAMP_MACROS_SVH

// property checked only while out of reset
`define PSO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define PSO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/pso_upd_pkg.sv =====
// ----------------------------------------------------------------------------
// pso_upd_pkg
// register indexes and pipeline constants of the particle update block
// ----------------------------------------------------------------------------
package pso_upd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int PIPE_STAGES = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COGNITIVE_GAIN = 2'd0,
        CFG_SOCIAL_GAIN    = 2'd1,
        CFG_VELOCITY_LIMIT = 2'd2
    } t_cfg_reg;

endpackage

// ===== sv/pso_upd_pos_clamp.sv =====
// ----------------------------------------------------------------------------
// pso_upd_pos_clamp
// new position: saturating add, step window clamp, then control limit clamp
// ----------------------------------------------------------------------------
module pso_upd_pos_clamp #(
    parameter int DATA_WIDTH = 16
) (
    input  logic signed [DATA_WIDTH-1:0] i_position,
    input  logic signed [DATA_WIDTH-1:0] i_new_velocity,
    input  logic signed [DATA_WIDTH-1:0] i_step_hi,
    input  logic signed [DATA_WIDTH-1:0] i_step_lo,
    input  logic signed [DATA_WIDTH-1:0] i_upper_limit,
    input  logic signed [DATA_WIDTH-1:0] i_lower_limit,
    input  logic                         i_particle_valid,
    output logic signed [DATA_WIDTH-1:0] o_new_position
);

    localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH:0]   sum;
    logic signed [DATA_WIDTH-1:0] p_sat;
    logic signed [DATA_WIDTH-1:0] p_step;
    logic signed [DATA_WIDTH-1:0] p_lim;

    always_comb begin
        sum = (DATA_WIDTH+1)'(i_position) + (DATA_WIDTH+1)'(i_new_velocity);
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) begin
            p_sat = sum[DATA_WIDTH] ? D_MIN : D_MAX;
        end else begin
            p_sat = sum[DATA_WIDTH-1:0];
        end

        if (p_sat > i_step_hi) begin
            p_step = i_step_hi;
        end else if (p_sat < i_step_lo) begin
            p_step = i_step_lo;
        end else begin
            p_step = p_sat;
        end

        // upper test first, so with crossed limits a value above the upper limit resolves to upper
        if (p_step > i_upper_limit) begin
            p_lim = i_upper_limit;
        end else if (p_step < i_lower_limit) begin
            p_lim = i_lower_limit;
        end else begin
            p_lim = p_step;
        end

        o_new_position = i_particle_valid ? p_lim : i_position;
    end

endmodule

// ===== sv/pso_particle_update_du_clamp.sv =====
// ----------------------------------------------------------------------------
// pso_particle_update_du_clamp
// velocity and position update of one particle element, five stage pipeline
// ----------------------------------------------------------------------------
//  channel   | handshake                  | beat contents
//  ----------+----------------------------+-----------------------------------
//  input     | i_in_valid / o_in_stall    | inertia .. particle_valid fields
//  result    | o_out_valid / i_out_stall  | new_velocity, new_position
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  one beat per cycle in and out while the output is not stalled
//  stages: diff and w*v, gain products, draw products, velocity sum, position
//  stall ripples back only through full stages, bubbles are squeezed out
//  synchronous active low reset empties the pipe and restores the gains
// ----------------------------------------------------------------------------
module pso_particle_update_du_clamp #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pso_upd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [DATA_WIDTH-1:0]                i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]         i_inertia,
    input  logic signed [DATA_WIDTH-1:0]         i_velocity,
    input  logic signed [DATA_WIDTH-1:0]         i_position,
    input  logic signed [DATA_WIDTH-1:0]         i_own_best,
    input  logic signed [DATA_WIDTH-1:0]         i_swarm_best,
    input  logic [FRAC_BITS:0]                   i_draw_one,
    input  logic [FRAC_BITS:0]                   i_draw_two,
    input  logic signed [DATA_WIDTH-1:0]         i_reference,
    input  logic [DATA_WIDTH-2:0]                i_step_limit,
    input  logic signed [DATA_WIDTH-1:0]         i_upper_limit,
    input  logic signed [DATA_WIDTH-1:0]         i_lower_limit,
    input  logic                                 i_particle_valid,

    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [DATA_WIDTH-1:0]         o_new_velocity,
    output logic signed [DATA_WIDTH-1:0]         o_new_position
);

    localparam int NS = pso_upd_pkg::PIPE_STAGES;
    localparam int D  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2 * D + F + 2;
    localparam int PW = 2 * D;
    localparam int RW = D + F + 2;

    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-D+1){1'b0}}, {(D-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    localparam logic [D-1:0] GAIN_RST = D'(2) << F;
    localparam logic [D-2:0] VLIM_RST = (D-1)'(1) << F;

    function automatic logic signed [D-1:0] f_sat(input logic signed [SW-1:0] a);
        logic signed [D-1:0] r;
        if (a > SAT_MAX) begin
            r = SAT_MAX[D-1:0];
        end else if (a < SAT_MIN) begin
            r = SAT_MIN[D-1:0];
        end else begin
            r = a[D-1:0];
        end
        return r;
    endfunction

    // configuration registers
    logic signed [D-1:0] r_cognitive_gain;
    logic signed [D-1:0] r_social_gain;
    logic [D-2:0]        r_velocity_limit;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cognitive_gain <= GAIN_RST;
            r_social_gain    <= GAIN_RST;
            r_velocity_limit <= VLIM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pso_upd_pkg::CFG_COGNITIVE_GAIN: r_cognitive_gain <= i_cfg_data;
                pso_upd_pkg::CFG_SOCIAL_GAIN:    r_social_gain    <= i_cfg_data;
                pso_upd_pkg::CFG_VELOCITY_LIMIT: r_velocity_limit <= i_cfg_data[D-2:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    assign o_in_stall = !en[0] || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: differences, step window, inertia product
    logic signed [PW-1:0] r1_prod_a;
    logic signed [D-1:0]  r1_d1, r1_d2, r1_v, r1_x, r1_hi, r1_lo, r1_ub, r1_lb;
    logic [F:0]           r1_r1, r1_r2;
    logic                 r1_pv;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_prod_a <= i_inertia * i_velocity;
            r1_d1     <= f_sat(SW'(i_own_best) - SW'(i_position));
            r1_d2     <= f_sat(SW'(i_swarm_best) - SW'(i_position));
            r1_hi     <= f_sat(SW'(i_reference) + SW'(i_step_limit));
            r1_lo     <= f_sat(SW'(i_reference) - SW'(i_step_limit));
            r1_v      <= i_velocity;
            r1_x      <= i_position;
            r1_ub     <= i_upper_limit;
            r1_lb     <= i_lower_limit;
            r1_r1     <= i_draw_one;
            r1_r2     <= i_draw_two;
            r1_pv     <= i_particle_valid;
        end
    end

    // stage 2: gain products, inertia product scaled
    logic signed [PW-1:0] r2_m1, r2_m2;
    logic signed [D-1:0]  r2_ta, r2_v, r2_x, r2_hi, r2_lo, r2_ub, r2_lb;
    logic [F:0]           r2_r1, r2_r2;
    logic                 r2_pv;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_ta <= f_sat(SW'(r1_prod_a >>> F));
            r2_m1 <= r_cognitive_gain * r1_d1;
            r2_m2 <= r_social_gain * r1_d2;
            r2_v  <= r1_v;
            r2_x  <= r1_x;
            r2_hi <= r1_hi;
            r2_lo <= r1_lo;
            r2_ub <= r1_ub;
            r2_lb <= r1_lb;
            r2_r1 <= r1_r1;
            r2_r2 <= r1_r2;
            r2_pv <= r1_pv;
        end
    end

    // stage 3: scaled gain terms times random draws
    logic signed [D-1:0]  s3_g1, s3_g2;
    logic signed [RW-1:0] r3_p1, r3_p2;
    logic signed [D-1:0]  r3_ta, r3_v, r3_x, r3_hi, r3_lo, r3_ub, r3_lb;
    logic                 r3_pv;

    always_comb begin
        s3_g1 = f_sat(SW'(r2_m1 >>> F));
        s3_g2 = f_sat(SW'(r2_m2 >>> F));
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_p1 <= s3_g1 * $signed({1'b0, r2_r1});
            r3_p2 <= s3_g2 * $signed({1'b0, r2_r2});
            r3_ta <= r2_ta;
            r3_v  <= r2_v;
            r3_x  <= r2_x;
            r3_hi <= r2_hi;
            r3_lo <= r2_lo;
            r3_ub <= r2_ub;
            r3_lb <= r2_lb;
            r3_pv <= r2_pv;
        end
    end

    // stage 4: velocity sum, saturate, magnitude limit; an invalid particle keeps its velocity
    logic signed [D-1:0]  s4_tb, s4_tc, s4_sum, s4_nv, s4_vmax, s4_vmin;
    logic signed [D+1:0]  s4_acc;
    logic signed [D-1:0]  r4_nv, r4_x, r4_hi, r4_lo, r4_ub, r4_lb;
    logic                 r4_pv;

    always_comb begin
        s4_tb   = f_sat(SW'(r3_p1 >>> F));
        s4_tc   = f_sat(SW'(r3_p2 >>> F));
        s4_acc  = (D+2)'(r3_ta) + (D+2)'(s4_tb) + (D+2)'(s4_tc);
        s4_sum  = f_sat(SW'(s4_acc));
        s4_vmax = $signed({1'b0, r_velocity_limit});
        s4_vmin = -s4_vmax;
        if (s4_sum > s4_vmax) begin
            s4_nv = s4_vmax;
        end else if (s4_sum < s4_vmin) begin
            s4_nv = s4_vmin;
        end else begin
            s4_nv = s4_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_nv <= r3_pv ? s4_nv : r3_v;
            r4_x  <= r3_x;
            r4_hi <= r3_hi;
            r4_lo <= r3_lo;
            r4_ub <= r3_ub;
            r4_lb <= r3_lb;
            r4_pv <= r3_pv;
        end
    end

    // stage 5: position clamp into the output register
    logic signed [D-1:0] s5_np;
    logic signed [D-1:0] r5_nv, r5_np;

    pso_upd_pos_clamp #(
        .DATA_WIDTH(D)
    ) u_pos_clamp (
        .i_position      (r4_x),
        .i_new_velocity  (r4_nv),
        .i_step_hi       (r4_hi),
        .i_step_lo       (r4_lo),
        .i_upper_limit   (r4_ub),
        .i_lower_limit   (r4_lb),
        .i_particle_valid(r4_pv),
        .o_new_position  (s5_np)
    );

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r5_nv <= r4_nv;
            r5_np <= s5_np;
        end
    end

    assign o_out_valid    = r_vld[NS-1];
    assign o_new_velocity = r5_nv;
    assign o_new_position = r5_np;

endmodule

// ===== sv/pso_upd_checker.sv =====
// ----------------------------------------------------------------------------
// pso_upd_checker
// port level checks of the particle update pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "pso_particle_update_du_clamp_macros.svh"

module pso_upd_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_WIDTH-1:0] o_new_velocity,
    input logic [DATA_WIDTH-1:0] o_new_position
);

    localparam int LAT = pso_upd_pkg::PIPE_STAGES;

    logic                      in_beat;
    logic                      out_held;
    logic [2*DATA_WIDTH-1:0]   out_pair;
    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign out_pair = {o_new_velocity, o_new_position};

    // reset empties the pipe
    `PSO_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // out of reset, back pressure only ever comes from a full, stalled output
    `PSO_ASSERT(a_stall_src, o_in_stall |-> out_held, "input stalled while output free")

    // a stalled result holds
    `PSO_ASSERT(a_out_hold, out_held |=> (o_out_valid && $stable(out_pair)), "stalled result changed")

    // an input beat comes out as a result beat when the output is not stalled while it passes the pipe
    `PSO_ASSERT(a_latency, in_beat ##1 (!i_out_stall)[*(LAT-1)] |=> o_out_valid, "beat lost in pipe")

endmodule

bind pso_particle_update_du_clamp pso_upd_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_pso_upd_checker (.*);
